// ===== rtl/slntl_pkg.sv =====
`default_nettype none

package slntl_pkg;

   // item kinds carried in req_tuser
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   // word positions inside a bank, bits [7:6] of the offset
   localparam logic [1:0] OFS_W0   = 2'b00;
   localparam logic [1:0] OFS_W1   = 2'b01;
   localparam logic [1:0] OFS_LINK = 2'b11;

   localparam logic [15:0] TIMER_MARK = 16'hFFFF;
   localparam logic [9:0]  NO_LINE    = 10'h3FF;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_W1   = 6'b000010,
      ST_W0   = 6'b000100,
      ST_LINK = 6'b001000,
      ST_NEXT = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   // scanline of a timer entry, modulo 512
   function automatic logic [8:0] timer_line(input logic [15:0] w0);
      logic [4:0] rows;
      logic [8:0] height;
      rows   = {1'b0, w0[3:0]} + 5'd1;
      height = {1'b0, rows, 3'b000};
      return 9'd255 - w0[13:5] - height;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sprite_list_next_timer_line_unit.sv =====
`default_nettype none

// channel   direction  handshake              payload
// req_      in         req_tvalid/req_tready  tuser: op; tdata: word_addr, word_data, scanline
// rsp_      out        rsp_tvalid/rsp_tready  tdata: next_line, changed
// csr_      in         csr_valid/csr_ready    csr_data: walked bank
//
// a write item is handled as it is taken; an evaluate item walks the list entry by entry
// through the single read port of the sprite ram, which serves three reads (second word,
// first word, link) per entry
// reset is synchronous; no clearing pass, sprite ram is undefined until written
// the result sits in an output register, so a new item is taken while it waits;
// a finished walk holds in its last state while that register is still full

module sprite_list_next_timer_line_unit #(
   parameter int LIST_ENTRIES = 64,
   parameter int BANK_COUNT   = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [10:0] word_addr, [26:11] word_data, [35:27] scanline, [39:36] zero
   input  wire logic [slntl_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] op
   input  wire logic [0:0]                         req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [9:0] next_line (signed), [10] changed, [15:11] zero
   output logic [slntl_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [2:0]                         csr_data
);

   localparam int ENTRY_BITS = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;
   localparam int BANK_BITS  = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
   localparam int RAM_WORDS  = BANK_COUNT * 256;
   localparam int RAM_AW     = $clog2(RAM_WORDS);

   // request fields
   logic        req_op;
   logic [10:0] req_addr;
   logic [15:0] req_word;
   logic [8:0]  req_line;
   logic        req_fire;

   assign req_op   = req_tuser[0];
   assign req_addr = req_tdata[10:0];
   assign req_word = req_tdata[26:11];
   assign req_line = req_tdata[35:27];
   assign req_fire = req_tvalid && req_tready;

   // control and walk state
   slntl_pkg::state_type    state_ff, state_in;
   logic [ENTRY_BITS-1:0]   e_ff, e_in;
   logic [8:0]              line_ff, line_in;
   logic [8:0]              best_ff, best_in;
   logic                    found_ff, found_in;
   logic                    timer_ff, timer_in;
   logic [LIST_ENTRIES-1:0] visited_ff, visited_in;
   logic [BANK_BITS-1:0]    bank_ff, bank_in;
   logic [9:0]              last_ff, last_in;

   // output register
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic signed [9:0]       rsp_line_ff, rsp_line_in;
   logic                    rsp_changed_ff, rsp_changed_in;
   logic                    rsp_load;

   // sprite ram, one write port and one registered read port
   logic [15:0]             sprite_mem [RAM_WORDS];
   logic [15:0]             rd_data_ff;
   logic [RAM_AW-1:0]       rd_addr;
   logic [ENTRY_BITS-1:0]   rd_entry;
   logic [1:0]              rd_ofs;
   logic                    mem_we;

   logic [ENTRY_BITS-1:0]   e_next;
   logic [8:0]              y_line;
   logic [9:0]              result;

   assign req_tready = (state_ff == slntl_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign mem_we     = req_fire && (req_op == slntl_pkg::OP_WRITE)
                       && ({1'b0, req_addr} < 12'(RAM_WORDS));
   assign rd_addr    = RAM_AW'({bank_ff, rd_ofs, 6'(rd_entry)});
   assign y_line     = slntl_pkg::timer_line(rd_data_ff);
   assign result     = found_ff ? {1'b0, best_ff} : slntl_pkg::NO_LINE;

   // active bank folded into range on each csr write
   always_comb begin
      logic [3:0] v;
      v = {1'b0, csr_data};
      for (int i = 0; i < 8; i++) begin
         if (v >= 4'(BANK_COUNT)) v = v - 4'(BANK_COUNT);
      end
      bank_in = csr_valid ? v[BANK_BITS-1:0] : bank_ff;
   end

   // link word folded into the list
   always_comb begin
      logic [6:0] v;
      v = {1'b0, rd_data_ff[5:0]};
      for (int i = 0; i < 8; i++) begin
         if (v >= 7'(LIST_ENTRIES)) v = v - 7'(LIST_ENTRIES);
      end
      e_next = v[ENTRY_BITS-1:0];
   end

   always_comb begin
      state_in       = state_ff;
      e_in           = e_ff;
      line_in        = line_ff;
      best_in        = best_ff;
      found_in       = found_ff;
      timer_in       = timer_ff;
      visited_in     = visited_ff;
      last_in        = last_ff;
      rd_entry       = e_ff;
      rd_ofs         = slntl_pkg::OFS_W1;
      rsp_load       = 1'b0;
      rsp_line_in    = rsp_line_ff;
      rsp_changed_in = rsp_changed_ff;

      case (state_ff)
         slntl_pkg::ST_IDLE: begin
            if (req_fire && req_op == slntl_pkg::OP_EVAL) begin
               e_in       = '0;
               line_in    = req_line;
               best_in    = req_line;
               found_in   = 1'b0;
               visited_in = '0;
               state_in   = slntl_pkg::ST_W1;
            end
         end
         slntl_pkg::ST_W1: begin
            // second word of the current entry
            rd_ofs   = slntl_pkg::OFS_W1;
            state_in = slntl_pkg::ST_W0;
         end
         slntl_pkg::ST_W0: begin
            timer_in = (rd_data_ff == slntl_pkg::TIMER_MARK);
            rd_ofs   = slntl_pkg::OFS_W0;
            state_in = slntl_pkg::ST_LINK;
         end
         slntl_pkg::ST_LINK: begin
            // first word is here; fold it into the running best
            if (timer_ff) begin
               found_in = 1'b1;
               if (best_ff <= line_ff) begin
                  if ((y_line <= line_ff && y_line < best_ff) || y_line > line_ff) begin
                     best_in = y_line;
                  end
               end else if (y_line < best_ff) begin
                  best_in = y_line;
               end
            end
            visited_in[e_ff] = 1'b1;
            rd_ofs           = slntl_pkg::OFS_LINK;
            state_in         = slntl_pkg::ST_NEXT;
         end
         slntl_pkg::ST_NEXT: begin
            // link is here; start the next entry straight away
            if (visited_ff[e_next]) begin
               state_in = slntl_pkg::ST_DONE;
            end else begin
               e_in     = e_next;
               rd_entry = e_next;
               rd_ofs   = slntl_pkg::OFS_W1;
               state_in = slntl_pkg::ST_W0;
            end
         end
         slntl_pkg::ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load       = 1'b1;
               rsp_line_in    = result;
               rsp_changed_in = (result != last_ff);
               last_in        = result;
               state_in       = slntl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = slntl_pkg::ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sprite_mem[req_addr[RAM_AW-1:0]] <= req_word;
      end
      rd_data_ff <= sprite_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= slntl_pkg::ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         last_ff       <= slntl_pkg::NO_LINE;
         bank_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         last_ff       <= last_in;
         bank_ff       <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff           <= e_in;
      line_ff        <= line_in;
      best_ff        <= best_in;
      found_ff       <= found_in;
      timer_ff       <= timer_in;
      visited_ff     <= visited_in;
      rsp_line_ff    <= rsp_line_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'b00000, rsp_changed_ff, rsp_line_ff};

`ifndef SYNTHESIS
   // changed flag compares against the result delivered before
   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_changed_ff == (rsp_line_ff != $past(last_ff))))
      else $error("changed flag does not match previous result");

   // a found line always lies in 0..511
   a_line_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (rsp_line_ff == slntl_pkg::NO_LINE || !rsp_line_ff[9]))
      else $error("next_line out of range");

   // an entry is never evaluated twice in one walk
   a_single_visit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == slntl_pkg::ST_W0) |-> !visited_ff[e_ff])
      else $error("list entry visited twice");
`endif

endmodule

`default_nettype wire
